>>> src/lrr_pkg.sv
// lrr_pkg: shared types, constants and helper functions for the line and rectangle rasterizer
// no dependencies; used by every module under src
`timescale 1ns / 1ps
`default_nettype none

package lrr_pkg;

  localparam int DISP_WIDTH  = 320;
  localparam int DISP_HEIGHT = 240;
  localparam int COORD_BITS  = 12;
  localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;

  localparam int DELTA_W = COORD_BITS + 1;
  localparam int ERR_W   = COORD_BITS + 3;
  localparam int COLOR_W = 18;
  localparam int CHAN_W  = 6;
  localparam int ADDR_W  = 18;

  // pixel coordinate widths once a position is known to be on the display
  localparam int PX_W = $clog2(DISP_WIDTH + 1);
  localparam int PY_W = $clog2(DISP_HEIGHT + 1);

  localparam int IQ_DEPTH = 4;
  localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
  localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);
  localparam int OQ_RES_W = $clog2(OQ_DEPTH + 3);

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    KIND_LINE    = 2'd0,
    KIND_OUTLINE = 2'd1,
    KIND_FILL    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef struct packed {
    logic               op;
    logic [1:0]         kind;
    coord_t             coord_x;
    coord_t             coord_y;
    coord_t             far_x;
    coord_t             far_y;
    logic [COLOR_W-1:0] color_rgb666;
  } in_item_t;

  typedef struct packed {
    logic              pixel_valid;
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        red8;
    logic [7:0]        green8;
    logic [7:0]        blue8;
    logic              done_res;
  } out_item_t;

  // classified item: for rectangles x1/y1 hold the far corner already saturated
  typedef struct packed {
    logic               is_step;
    kind_t              kind;
    logic               active;
    coord_t             x0;
    coord_t             y0;
    coord_t             x1;
    coord_t             y1;
    coord_t             height;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  typedef struct packed {
    logic avail;
    logic take;
  } cmd_hs_t;

  typedef struct packed {
    coord_t                   cur_x;
    coord_t                   cur_y;
    coord_t                   end_x;
    coord_t                   end_y;
    logic [DELTA_W-1:0]       dx;
    logic [DELTA_W-1:0]       dy;
    logic                     sxn;
    logic                     syn;
    logic signed [ERR_W-1:0]  err;
  } line_t;

  typedef struct packed {
    logic               lit;
    logic               done;
    logic [PX_W-1:0]    x;
    logic [PY_W-1:0]    y;
    logic [COLOR_W-1:0] color;
  } pix_t;

  function automatic line_t load_line(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    line_t                     r;
    logic signed [COORD_BITS:0] ddx;
    logic signed [COORD_BITS:0] ddy;
    ddx = {x1[COORD_BITS-1], x1} - {x0[COORD_BITS-1], x0};
    ddy = {y1[COORD_BITS-1], y1} - {y0[COORD_BITS-1], y0};
    r.cur_x = x0;
    r.cur_y = y0;
    r.end_x = x1;
    r.end_y = y1;
    r.dx    = ddx[COORD_BITS] ? DELTA_W'(-ddx) : DELTA_W'(ddx);
    r.dy    = ddy[COORD_BITS] ? DELTA_W'(-ddy) : DELTA_W'(ddy);
    r.sxn   = !(x0 < x1);
    r.syn   = !(y0 < y1);
    r.err   = $signed({2'b00, r.dx}) - $signed({2'b00, r.dy});
    return r;
  endfunction

  // far rectangle edge, clamped to the largest coordinate
  function automatic coord_t far_edge(coord_t org, coord_t size);
    logic signed [COORD_BITS:0] t;
    t = {org[COORD_BITS-1], org} + {size[COORD_BITS-1], size} - 1'b1;
    if (t > COORD_MAX) begin
      return coord_t'(COORD_MAX);
    end
    return t[COORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

>>> src/line_and_rect_rasterizer.sv
// line_and_rect_rasterizer: top level, front queue, primitive walker and result pipeline
// depends on lrr_pkg, lrr_front, lrr_back, lrr_emit
//
//   channel   ports                       direction  moves
//   input     push, full, in_item         in         start and step items
//   result    empty, pop, out_item        out        one result per item
//
// one item per cycle sustained while the result queue has room; a taken item's
// result passes the row multiply and times three registers and a result queue slot.
// the walker is the single loop: one Bresenham step or segment load per taken step item.
// reset is synchronous, active low; it empties both queues and leaves the block idle.
// with pop held low the four-entry result queue fills, the walker stops, then the
// four-entry input queue fills and full rises.
`timescale 1ns / 1ps
`default_nettype none

module line_and_rect_rasterizer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire lrr_pkg::in_item_t in_item,
  output logic                   empty,
  input  wire logic              pop,
  output lrr_pkg::out_item_t     out_item
);

  lrr_pkg::cmd_hs_t cmd_hs;
  lrr_pkg::cmd_t    cmd;
  logic             cmd_take;
  logic             emit_ready;
  logic             pix_valid;
  lrr_pkg::pix_t    pix;

  lrr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .cmd_hs_o (cmd_hs),
    .cmd_take (cmd_take),
    .cmd      (cmd)
  );

  lrr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_avail  (cmd_hs.avail),
    .cmd        (cmd),
    .cmd_take   (cmd_take),
    .emit_ready (emit_ready),
    .pix_valid  (pix_valid),
    .pix        (pix)
  );

  lrr_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_valid  (pix_valid),
    .pix        (pix),
    .emit_ready (emit_ready),
    .empty      (empty),
    .pop        (pop),
    .out_item   (out_item)
  );

  a_take_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> cmd_hs.avail && cmd_hs.take)
    else $error("walker took an item from an empty queue");

  a_start_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_hs.take && !cmd.is_step) |-> (pix_valid && !pix.lit))
    else $error("start item produced a pixel");

  a_lit_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (pix_valid && pix.lit) |->
      (pix.x < lrr_pkg::DISP_WIDTH) && (pix.y < lrr_pkg::DISP_HEIGHT))
    else $error("lit pixel outside the display");

  a_dark_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_item.pixel_valid) |->
      (out_item.byte_address == '0) && (out_item.red8 == '0) &&
      (out_item.green8 == '0) && (out_item.blue8 == '0))
    else $error("dropped pixel carries address or color");

endmodule

`default_nettype wire

>>> src/lrr_front.sv
// lrr_front: takes input items, classifies them and holds them in a short queue
// depends on lrr_pkg
`timescale 1ns / 1ps
`default_nettype none

module lrr_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire lrr_pkg::in_item_t in_item,
  output lrr_pkg::cmd_hs_t       cmd_hs_o,
  input  wire logic              cmd_take,
  output lrr_pkg::cmd_t          cmd
);

  lrr_pkg::cmd_t                   cls;
  logic                            rect_ok;
  lrr_pkg::cmd_t                   mem_r [lrr_pkg::IQ_DEPTH];
  logic [lrr_pkg::IQ_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [lrr_pkg::IQ_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [lrr_pkg::IQ_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                            wr_en;
  logic                            rd_en;

  always_comb begin
    rect_ok     = (in_item.far_x > 0) && (in_item.far_y > 0);
    cls.is_step = (in_item.op == lrr_pkg::OP_STEP);
    cls.kind    = lrr_pkg::kind_t'(in_item.kind);
    cls.color   = in_item.color_rgb666;
    cls.height  = in_item.far_y;
    cls.x0      = in_item.coord_x;
    cls.y0      = in_item.coord_y;
    cls.x1      = in_item.far_x;
    cls.y1      = in_item.far_y;
    cls.active  = 1'b0;
    unique case (cls.kind) inside
      lrr_pkg::KIND_LINE: begin
        cls.active = 1'b1;
      end
      lrr_pkg::KIND_OUTLINE, lrr_pkg::KIND_FILL: begin
        cls.active = rect_ok;
        cls.x1     = lrr_pkg::far_edge(in_item.coord_x, in_item.far_x);
        cls.y1     = lrr_pkg::far_edge(in_item.coord_y, in_item.far_y);
      end
      default: begin
        cls.active = 1'b0;
      end
    endcase
  end

  assign full           = (cnt_r == lrr_pkg::IQ_CNT_W'(lrr_pkg::IQ_DEPTH));
  assign cmd_hs_o.avail = (cnt_r != '0);
  assign cmd_hs_o.take  = rd_en;
  assign wr_en          = push && !full;
  assign rd_en          = cmd_take && cmd_hs_o.avail;
  assign cmd            = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

>>> src/lrr_back.sv
// lrr_back: primitive walker, one queued item per cycle with emit_ready high, Bresenham stepping, segment sequencing
// depends on lrr_pkg
`timescale 1ns / 1ps
`default_nettype none

module lrr_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_avail,
  input  wire lrr_pkg::cmd_t  cmd,
  output logic                cmd_take,
  input  wire logic           emit_ready,
  output logic                pix_valid,
  output lrr_pkg::pix_t       pix
);

  localparam logic [1:0] SEG_TOP    = 2'd0;
  localparam logic [1:0] SEG_LEFT   = 2'd1;
  localparam logic [1:0] SEG_RIGHT  = 2'd2;
  localparam logic [1:0] SEG_BOTTOM = 2'd3;
  localparam int         LAST_SEG   = 3;

  logic                                busy_r, busy_nxt;
  lrr_pkg::kind_t                      kind_r, kind_nxt;
  lrr_pkg::line_t                      ln_r, ln_nxt;
  lrr_pkg::coord_t                     org_x_r, org_x_nxt;
  lrr_pkg::coord_t                     org_y_r, org_y_nxt;
  lrr_pkg::coord_t                     cx2_r, cx2_nxt;
  lrr_pkg::coord_t                     cy2_r, cy2_nxt;
  lrr_pkg::coord_t                     height_r, height_nxt;
  logic [lrr_pkg::COORD_BITS-1:0]      seg_r, seg_nxt;
  logic [lrr_pkg::COLOR_W-1:0]         color_r, color_nxt;

  logic                                fire;
  logic                                inb;
  logic                                at_end;
  logic                                more;
  logic [lrr_pkg::COORD_BITS-1:0]      seg_n;
  logic signed [lrr_pkg::COORD_BITS:0] ny_wide;
  lrr_pkg::coord_t                     sx0, sy0, sx1, sy1;
  lrr_pkg::line_t                      seg_line;
  logic signed [lrr_pkg::ERR_W:0]      e2, ndy, pdx;
  logic signed [lrr_pkg::ERR_W-1:0]    err_n;

  assign fire     = cmd_avail && emit_ready;
  assign cmd_take = fire;

  always_comb begin
    inb = (ln_r.cur_x >= 0) && (ln_r.cur_x < lrr_pkg::DISP_WIDTH) &&
          (ln_r.cur_y >= 0) && (ln_r.cur_y < lrr_pkg::DISP_HEIGHT);
    at_end  = (ln_r.cur_x == ln_r.end_x) && (ln_r.cur_y == ln_r.end_y);
    seg_n   = seg_r + 1'b1;
    ny_wide = {org_y_r[lrr_pkg::COORD_BITS-1], org_y_r} + {1'b0, seg_n};

    more = 1'b0;
    if (kind_r == lrr_pkg::KIND_OUTLINE) begin
      more = (seg_r < lrr_pkg::COORD_BITS'(LAST_SEG));
    end else if (kind_r == lrr_pkg::KIND_FILL) begin
      more = (seg_n < height_r) && (ny_wide <= lrr_pkg::COORD_MAX);
    end

    // endpoints of the next outline segment or fill row
    sx0 = org_x_r;
    sy0 = org_y_r;
    sx1 = cx2_r;
    sy1 = cy2_r;
    if (kind_r == lrr_pkg::KIND_FILL) begin
      sy0 = ny_wide[lrr_pkg::COORD_BITS-1:0];
      sy1 = ny_wide[lrr_pkg::COORD_BITS-1:0];
    end else begin
      unique case (seg_n[1:0])
        SEG_TOP: begin
          sy1 = org_y_r;
        end
        SEG_LEFT: begin
          sx1 = org_x_r;
        end
        SEG_RIGHT: begin
          sx0 = cx2_r;
        end
        SEG_BOTTOM: begin
          sy0 = cy2_r;
        end
        default: begin
          sy1 = org_y_r;
        end
      endcase
    end
    seg_line = lrr_pkg::load_line(sx0, sy0, sx1, sy1);

    e2  = {ln_r.err, 1'b0};
    ndy = -$signed({3'b000, ln_r.dy});
    pdx = $signed({3'b000, ln_r.dx});
  end

  always_comb begin
    busy_nxt   = busy_r;
    kind_nxt   = kind_r;
    ln_nxt     = ln_r;
    org_x_nxt  = org_x_r;
    org_y_nxt  = org_y_r;
    cx2_nxt    = cx2_r;
    cy2_nxt    = cy2_r;
    height_nxt = height_r;
    seg_nxt    = seg_r;
    color_nxt  = color_r;
    err_n      = ln_r.err;

    pix_valid  = fire;
    pix.lit    = 1'b0;
    pix.done   = 1'b0;
    pix.x      = ln_r.cur_x[lrr_pkg::PX_W-1:0];
    pix.y      = ln_r.cur_y[lrr_pkg::PY_W-1:0];
    pix.color  = color_r;

    if (fire) begin
      if (!cmd.is_step) begin
        kind_nxt   = cmd.kind;
        seg_nxt    = '0;
        color_nxt  = cmd.color;
        busy_nxt   = cmd.active;
        org_x_nxt  = cmd.x0;
        org_y_nxt  = cmd.y0;
        cx2_nxt    = cmd.x1;
        cy2_nxt    = cmd.y1;
        height_nxt = cmd.height;
        // top edge of a rectangle runs from the origin to the far x
        ln_nxt     = lrr_pkg::load_line(cmd.x0, cmd.y0, cmd.x1,
                                        (cmd.kind == lrr_pkg::KIND_LINE) ? cmd.y1 : cmd.y0);
        pix.done   = !cmd.active;
      end else if (!busy_r) begin
        pix.done = 1'b1;
      end else begin
        pix.lit = inb;
        if (at_end) begin
          if (more) begin
            seg_nxt = seg_n;
            ln_nxt  = seg_line;
          end else begin
            busy_nxt = 1'b0;
            pix.done = 1'b1;
          end
        end else begin
          if (e2 > ndy) begin
            err_n        = err_n - $signed({2'b00, ln_r.dy});
            ln_nxt.cur_x = ln_r.sxn ? ln_r.cur_x - 1'b1 : ln_r.cur_x + 1'b1;
          end
          if (e2 < pdx) begin
            err_n        = err_n + $signed({2'b00, ln_r.dx});
            ln_nxt.cur_y = ln_r.syn ? ln_r.cur_y - 1'b1 : ln_r.cur_y + 1'b1;
          end
          ln_nxt.err = err_n;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      kind_r   <= lrr_pkg::KIND_LINE;
      ln_r     <= '0;
      org_x_r  <= '0;
      org_y_r  <= '0;
      cx2_r    <= '0;
      cy2_r    <= '0;
      height_r <= '0;
      seg_r    <= '0;
      color_r  <= '0;
    end else begin
      busy_r   <= busy_nxt;
      kind_r   <= kind_nxt;
      ln_r     <= ln_nxt;
      org_x_r  <= org_x_nxt;
      org_y_r  <= org_y_nxt;
      cx2_r    <= cx2_nxt;
      cy2_r    <= cy2_nxt;
      height_r <= height_nxt;
      seg_r    <= seg_nxt;
      color_r  <= color_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/lrr_emit.sv
// lrr_emit: two-stage address pipeline (row multiply, then times three) and result queue
// depends on lrr_pkg
`timescale 1ns / 1ps
`default_nettype none

module lrr_emit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           pix_valid,
  input  wire lrr_pkg::pix_t  pix,
  output logic                emit_ready,
  output logic                empty,
  input  wire logic           pop,
  output lrr_pkg::out_item_t  out_item
);

  localparam int AW = lrr_pkg::ADDR_W;
  localparam int CW = lrr_pkg::CHAN_W;

  logic                           v1_r;
  logic                           lit1_r;
  logic                           done1_r;
  logic [lrr_pkg::COLOR_W-1:0]    color1_r;
  logic [AW-1:0]                  lin1_r, lin1_nxt;
  logic                           v2_r;
  lrr_pkg::out_item_t             res2_r, res2_nxt;

  lrr_pkg::out_item_t             mem_r [lrr_pkg::OQ_DEPTH];
  logic [lrr_pkg::OQ_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [lrr_pkg::OQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [lrr_pkg::OQ_RES_W-1:0]   reserved;
  logic                           rd_en;

  // slots already promised to items still in the pipeline count as taken
  assign reserved   = lrr_pkg::OQ_RES_W'(cnt_r) + lrr_pkg::OQ_RES_W'(v1_r)
                    + lrr_pkg::OQ_RES_W'(v2_r);
  assign emit_ready = (reserved < lrr_pkg::OQ_RES_W'(lrr_pkg::OQ_DEPTH));
  assign empty      = (cnt_r == '0);
  assign rd_en      = pop && !empty;
  assign out_item   = mem_r[rd_ptr_r];

  always_comb begin
    lin1_nxt = AW'(pix.y) * AW'(lrr_pkg::DISP_WIDTH) + AW'(pix.x);

    res2_nxt.pixel_valid  = lit1_r;
    res2_nxt.done_res     = done1_r;
    res2_nxt.byte_address = '0;
    res2_nxt.red8         = '0;
    res2_nxt.green8       = '0;
    res2_nxt.blue8        = '0;
    if (lit1_r) begin
      res2_nxt.byte_address = lin1_r + {lin1_r[AW-2:0], 1'b0};
      res2_nxt.red8         = {color1_r[3*CW-1:2*CW], 2'b00};
      res2_nxt.green8       = {color1_r[2*CW-1:CW], 2'b00};
      res2_nxt.blue8        = {color1_r[CW-1:0], 2'b00};
    end

    cnt_nxt = cnt_r;
    if (v2_r && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!v2_r && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      v1_r  <= pix_valid;
      v2_r  <= v1_r;
      cnt_r <= cnt_nxt;
      if (v2_r) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    lit1_r   <= pix.lit;
    done1_r  <= pix.done;
    color1_r <= pix.color;
    lin1_r   <= lin1_nxt;
    res2_r   <= res2_nxt;
    if (v2_r) begin
      mem_r[wr_ptr_r] <= res2_r;
    end
  end

endmodule

`default_nettype wire
